// ===== rtl/core/ansi_text_terminal_engine_macros.svh =====
// Assertion macros for the ANSI text terminal engine checker.
// Depends on nothing; included by the checker file.
`ifndef ANSI_TEXT_TERMINAL_ENGINE_MACROS_SVH
`define ANSI_TEXT_TERMINAL_ENGINE_MACROS_SVH
`define ATTE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: label failed");
`define ATTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: label failed");
`endif

// ===== rtl/core/atte_pkg.sv =====
// Shared constants and types for the ANSI text terminal engine.
// No dependencies.
package atte_pkg;
    localparam int ROWS = 256;
    localparam int COLS = 128;
    localparam int MAX_PARAMS = 8;
    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLS);
    localparam int AW = RW + CW;
    localparam int PW = $clog2(MAX_PARAMS);
    localparam logic [7:0] CH_ESC = 8'd27;
    localparam logic [7:0] CH_BEL = 8'd7;
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_BS = 8'd8;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_LBR = 8'h5B;
    localparam logic [7:0] CH_RBR = 8'h5D;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [15:0] PARAM_MAX = 16'hFFFF;
    localparam logic [7:0] WIDTH_RESET = 8'd80;
    localparam logic [0:0] ADDR_COLUMNS = 1'b0;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [6:0]    wdata;
        logic [AW-1:0] raddr;
    } t_mem_req;
endpackage

// ===== rtl/core/atte_cell_ram.sv =====
// Character cell store: one write port, one registered read port.
// Depends on atte_pkg.
module atte_cell_ram
    import atte_pkg::*;
(
    input  logic       i_clk,
    input  t_mem_req   i_req,
    output logic [6:0] o_rdata
);
    logic [6:0] r_mem [0:ROWS*COLS-1];
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end
endmodule

// ===== rtl/core/ansi_text_terminal_engine.sv =====
// ANSI text terminal engine top level: parser, cursor, row sweeps.
// Depends on atte_pkg and atte_cell_ram.
// Usage: feed or read words enter on i_valid/o_ready; each word gives one
// result word on o_valid/i_ready holding a cell (reads) and the cursor.
// Config: APB write of columns_in_use where paddr[2] is 0; prdata reads it back.
// Sequencing: a plain feed gives its result in the cycle after accept; a
// read goes through S_READ, taking the registered cell RAM read, to S_OUT.
// A TAB writes one cell per cycle up to the next tab stop or the width. A
// newline clears a row. Erase line clears up to COLS cells, erase display
// up to ROWS*COLS cells, one cell per cycle via the single RAM write port.
// After reset a clearing pass writes zero to all ROWS*COLS cells
// before the first word is accepted; APB writes are still taken.
// The engine handles one word at a time. When the receiver stalls the
// result register holds and no new word is taken until it is emptied.
module ansi_text_terminal_engine
    import atte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [7:0]  i_stream_byte,
    input  logic [7:0]  i_read_row,
    input  logic [6:0]  i_read_col,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_cell_char,
    output logic [7:0]  o_cursor_row_out,
    output logic [6:0]  o_cursor_col_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [2:0] {S_INIT, S_IDLE, S_READ, S_TAB, S_CLEAR, S_OUT} t_state;

    t_state r_state;
    logic [7:0] r_width;
    logic [RW-1:0] r_top, r_crow;
    logic [CW:0] r_ccol;
    logic [1:0] r_ps;
    logic [PW-1:0] r_pidx;
    logic [15:0] r_p0, r_p1;
    logic [AW:0] r_cnt, r_end;
    logic [CW:0] r_stop;
    logic r_nl_after;
    logic r_rd_ok;
    logic [6:0] r_cell;
    t_mem_req mreq;
    logic [6:0] rdata;

    atte_cell_ram u_ram (.i_clk(i_clk), .i_req(mreq), .o_rdata(rdata));

    logic [CW:0] w;
    always_comb begin
        if (r_width < 8'd8) w = (CW+1)'(8);
        else if ({1'b0, r_width} > 9'(COLS)) w = (CW+1)'(COLS);
        else w = r_width[CW:0];
    end

    assign pready = 1'b1;
    assign prdata = {24'd0, r_width};
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    function automatic logic [RW-1:0] phys(input logic [RW-1:0] top, input logic [RW-1:0] lr);
        logic [RW:0] s;
        s = {1'b0, top} + {1'b0, lr};
        if (s >= (RW+1)'(ROWS)) s = s - (RW+1)'(ROWS);
        return s[RW-1:0];
    endfunction

    function automatic logic [15:0] add_digit(input logic [15:0] v, input logic [3:0] d);
        logic [19:0] n;
        n = {4'd0, v} * 20'd10 + {16'd0, d};
        return (n > 20'hFFFF) ? PARAM_MAX : n[15:0];
    endfunction

    logic [7:0] c;
    assign c = i_stream_byte;
    logic [RW-1:0] crow_phys;
    assign crow_phys = phys(r_top, r_crow);
    logic [15:0] cnt16;
    assign cnt16 = (r_p0 == 16'd0) ? 16'd1 : r_p0;

    // newline: advance cursor/top, return start cell of row to clear
    logic [RW-1:0] nl_row, nl_top;
    always_comb begin
        if (32'(r_crow) + 1 >= ROWS) begin
            nl_row = r_crow;
            nl_top = (32'(r_top) + 1 >= ROWS) ? '0 : r_top + 1'b1;
        end else begin
            nl_row = r_crow + 1'b1;
            nl_top = r_top;
        end
    end

    always_comb begin
        mreq = '0;
        mreq.raddr = {phys(r_top, i_read_row[RW-1:0]), i_read_col[CW-1:0]};
        if (r_state == S_INIT || r_state == S_CLEAR) begin
            mreq.we = 1'b1;
            mreq.waddr = r_cnt[AW-1:0];
        end else if (r_state == S_TAB) begin
            mreq.we = 1'b1;
            mreq.waddr = {crow_phys, r_ccol[CW-1:0]};
            mreq.wdata = CH_SP[6:0];
        end else if (r_state == S_IDLE && i_valid && !i_mode && r_ps == 2'd0) begin
            if (c >= 8'd32 && c < 8'd127 && r_ccol < (CW+1)'(COLS)) begin
                mreq.we = 1'b1;
                mreq.waddr = {crow_phys, r_ccol[CW-1:0]};
                mreq.wdata = c[6:0];
            end else if (c == CH_BS && r_ccol != '0) begin
                mreq.we = 1'b1;
                mreq.waddr = {crow_phys, r_ccol[CW-1:0] - 1'b1};
            end
        end
    end

    logic [AW:0] rowbase;
    logic [AW:0] nlbase;
    assign rowbase = {1'b0, crow_phys, {CW{1'b0}}};
    assign nlbase = {1'b0, phys(nl_top, nl_row), {CW{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_width <= WIDTH_RESET;
            r_top <= '0; r_crow <= '0; r_ccol <= '0;
            r_ps <= '0; r_pidx <= '0; r_p0 <= '0; r_p1 <= '0;
            r_cnt <= '0; r_end <= (AW+1)'(ROWS*COLS);
            r_nl_after <= 1'b0; r_rd_ok <= 1'b0; r_cell <= '0; r_stop <= '0;
        end else begin
            if (psel && penable && pwrite && paddr[2] == ADDR_COLUMNS)
                r_width <= pwdata[7:0];
            case (r_state)
                S_INIT, S_CLEAR: begin
                    if (r_cnt + 1'b1 >= r_end) begin
                        r_state <= (r_state == S_INIT) ? S_IDLE : S_OUT;
                        r_cnt <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_TAB: begin
                    if (r_ccol + 1'b1 >= r_stop || r_ccol + 1'b1 >= w) begin
                        if (r_ccol + 1'b1 >= w) begin
                            r_ccol <= '0; r_crow <= nl_row; r_top <= nl_top;
                            r_cnt <= nlbase; r_end <= nlbase + (AW+1)'(COLS);
                            r_state <= S_CLEAR;
                        end else begin
                            r_ccol <= r_ccol + 1'b1;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_ccol <= r_ccol + 1'b1;
                    end
                end
                S_READ: begin
                    r_cell <= r_rd_ok ? rdata : '0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                        r_cell <= '0;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_OUT;
                        if (i_mode) begin
                            r_rd_ok <= (32'(i_read_row) < ROWS) && (32'(i_read_col) < COLS);
                            r_state <= S_READ;
                        end else begin
                            case (r_ps)
                                2'd0: begin
                                    if (c == CH_ESC) r_ps <= 2'd1;
                                    else if (c == CH_LF) begin
                                        r_ccol <= '0; r_crow <= nl_row; r_top <= nl_top;
                                        r_cnt <= nlbase; r_end <= nlbase + (AW+1)'(COLS);
                                        r_state <= S_CLEAR;
                                    end else if (c == CH_CR) r_ccol <= '0;
                                    else if (c == CH_BS) begin
                                        if (r_ccol != '0) r_ccol <= r_ccol - 1'b1;
                                    end else if (c == CH_TAB) begin
                                        r_stop <= {r_ccol[CW:3] + 1'b1, 3'b000};
                                        if (r_ccol < w) r_state <= S_TAB;
                                        else begin
                                            r_ccol <= '0; r_crow <= nl_row; r_top <= nl_top;
                                            r_cnt <= nlbase;
                                            r_end <= nlbase + (AW+1)'(COLS);
                                            r_state <= S_CLEAR;
                                        end
                                    end else if (c >= 8'd32 && c < 8'd127) begin
                                        if (r_ccol + 1'b1 >= w) begin
                                            r_ccol <= '0; r_crow <= nl_row; r_top <= nl_top;
                                            r_cnt <= nlbase;
                                            r_end <= nlbase + (AW+1)'(COLS);
                                            r_state <= S_CLEAR;
                                        end else r_ccol <= r_ccol + 1'b1;
                                    end
                                end
                                2'd1: begin
                                    if (c == CH_LBR) begin
                                        r_ps <= 2'd2; r_pidx <= '0; r_p0 <= '0; r_p1 <= '0;
                                    end else if (c == CH_RBR) r_ps <= 2'd3;
                                    else r_ps <= 2'd0;
                                end
                                2'd2: begin
                                    if (c >= "0" && c <= "9") begin
                                        if (r_pidx == '0) r_p0 <= add_digit(r_p0, c[3:0]);
                                        else if (r_pidx == PW'(1)) r_p1 <= add_digit(r_p1, c[3:0]);
                                    end else if (c == CH_SEMI) begin
                                        if (32'(r_pidx) + 1 < MAX_PARAMS) begin
                                            r_pidx <= r_pidx + 1'b1;
                                            if (r_pidx == '0) r_p1 <= '0;
                                        end
                                    end else if (c >= "@" && c <= "~") begin
                                        r_ps <= 2'd0;
                                        case (c)
                                            "J": begin
                                                if (r_p0 >= 16'd2) begin
                                                    r_crow <= '0; r_ccol <= '0;
                                                    r_cnt <= '0;
                                                    r_end <= (AW+1)'(ROWS*COLS);
                                                    r_state <= S_CLEAR;
                                                end else if (r_p0 == 16'd0) begin
                                                    // rows wrap in the ring: sweep logical cells
                                                    r_cnt <= rowbase + (AW+1)'(r_ccol);
                                                    r_end <= rowbase + (AW+1)'(COLS)
                                                        + (AW+1)'((ROWS-1-32'(r_crow))*COLS);
                                                    r_state <= S_CLEAR;
                                                end
                                            end
                                            "K": begin
                                                if (r_p0 == 16'd0) begin
                                                    r_cnt <= rowbase + (AW+1)'(r_ccol);
                                                    r_end <= rowbase + (AW+1)'(COLS);
                                                end else if (r_p0 == 16'd1) begin
                                                    r_cnt <= rowbase;
                                                    r_end <= rowbase + (AW+1)'(r_ccol) + 1'b1;
                                                end else begin
                                                    r_cnt <= rowbase;
                                                    r_end <= rowbase + (AW+1)'(COLS);
                                                end
                                                r_state <= S_CLEAR;
                                            end
                                            "H": begin
                                                r_crow <= (r_p0 > 16'(ROWS)) ? RW'(ROWS-1)
                                                    : (r_p0 == 0 ? '0 : RW'(r_p0 - 1'b1));
                                                if (r_p1 == 0) r_ccol <= '0;
                                                else if (32'(r_p1) - 1 > 32'(w) - 1)
                                                    r_ccol <= w - 1'b1;
                                                else r_ccol <= (CW+1)'(r_p1 - 1'b1);
                                            end
                                            "A": r_crow <= (32'(r_crow) > 32'(cnt16))
                                                ? RW'(32'(r_crow) - 32'(cnt16)) : '0;
                                            "B": r_crow <= (32'(r_crow) + 32'(cnt16) > ROWS-1)
                                                ? RW'(ROWS-1) : RW'(32'(r_crow) + 32'(cnt16));
                                            "C": r_ccol <= (32'(r_ccol) + 32'(cnt16) > 32'(w) - 1)
                                                ? w - 1'b1 : (CW+1)'(32'(r_ccol) + 32'(cnt16));
                                            "D": r_ccol <= (32'(r_ccol) > 32'(cnt16))
                                                ? (CW+1)'(32'(r_ccol) - 32'(cnt16)) : '0;
                                            default: ;
                                        endcase
                                    end else r_ps <= 2'd0;
                                end
                                default: begin
                                    if (c == CH_BEL || c == CH_ESC) r_ps <= 2'd0;
                                end
                            endcase
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // clear sweeps past the ring end wrap around to physical row 0

    assign o_cell_char = r_cell;
    assign o_cursor_row_out = 8'(r_crow);
    assign o_cursor_col_out = r_ccol[6:0];
endmodule

// ===== rtl/core/atte_checker.sv =====
// Port-level checker for the ANSI text terminal engine, bound to the top.
// Depends on ansi_text_terminal_engine_macros.svh.
`include "ansi_text_terminal_engine_macros.svh"
module atte_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic       pready,
    input logic [6:0] o_cursor_col_out,
    input logic [6:0] o_cell_char
);
    `ATTE_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, o_valid, !o_ready)
    `ATTE_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `ATTE_ASSERT_NEXT(a_data_holds, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_cell_char) && $stable(o_cursor_col_out))
    `ATTE_ASSERT_NEXT(a_accept_result, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `ATTE_ASSERT_IMP(a_pready, i_clk, i_rst_n, 1'b1, pready)
endmodule

bind ansi_text_terminal_engine atte_checker u_atte_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .pready(pready),
    .o_cursor_col_out(o_cursor_col_out), .o_cell_char(o_cell_char)
);

// ===== verif/ansi_text_terminal_engine_checker.sv =====
// Result checker for the ANSI text terminal engine: shadow terminal model.
// Watches input and result channels; depends on atte_pkg.
module ansi_text_terminal_engine_checker
    import atte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic        i_mode,
    input  logic [7:0]  i_stream_byte,
    input  logic [7:0]  i_read_row,
    input  logic [6:0]  i_read_col,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [6:0]  o_cell_char,
    input  logic [7:0]  o_cursor_row_out,
    input  logic [6:0]  o_cursor_col_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {PS_TEXT, PS_ESC, PS_CSI, PS_OSC} parse_e;

    typedef struct packed {
        logic [6:0] ch;
        logic [7:0] row;
        logic [6:0] col;
    } term_view_t;

    logic [6:0]  screen [ROWS*COLS];
    int unsigned top_row;
    int unsigned cur_row;
    int unsigned cur_col;
    parse_e      pstate;
    int unsigned pidx;
    int unsigned arg0;
    int unsigned arg1;
    logic [7:0]  width_reg;
    term_view_t  expected_views[$];

    assign o_pending = expected_views.size();

    function automatic int unsigned cols_active();
        int unsigned w;
        w = width_reg;
        if (w < 8) w = 8;
        if (w > COLS) w = COLS;
        return w;
    endfunction

    function automatic int unsigned cell_addr(int unsigned lrow, int unsigned c);
        return ((top_row + lrow) % ROWS) * COLS + c;
    endfunction

    task automatic clear_row_from(int unsigned lrow, int unsigned from, int unsigned upto);
        for (int unsigned c = from; c < upto; c++) screen[cell_addr(lrow, c)] = '0;
    endtask

    task automatic line_feed();
        cur_col = 0;
        if (cur_row + 1 >= ROWS) begin
            top_row = (top_row + 1) % ROWS;
            cur_row = ROWS - 1;
        end else begin
            cur_row++;
        end
        clear_row_from(cur_row, 0, COLS);
    endtask

    function automatic int unsigned push_digit(int unsigned v, int unsigned d);
        int unsigned n;
        n = v * 10 + d;
        return n > PARAM_MAX ? PARAM_MAX : n;
    endfunction

    task automatic run_sequence(logic [7:0] fin);
        int unsigned cnt, w, p1;
        cnt = arg0 ? arg0 : 1;
        w = cols_active();
        case (fin)
            "J": begin
                if (arg0 >= 2) begin
                    for (int i = 0; i < ROWS*COLS; i++) screen[i] = '0;
                    cur_row = 0;
                    cur_col = 0;
                end else if (arg0 == 0) begin
                    clear_row_from(cur_row, cur_col, COLS);
                    for (int unsigned r = cur_row + 1; r < ROWS; r++)
                        clear_row_from(r, 0, COLS);
                end
            end
            "K": begin
                if (arg0 == 0) clear_row_from(cur_row, cur_col, COLS);
                else if (arg0 == 1) clear_row_from(cur_row, 0, cur_col + 1);
                else clear_row_from(cur_row, 0, COLS);
            end
            "H": begin
                p1 = arg1 ? arg1 : 1;
                cur_row = arg0 ? arg0 - 1 : 0;
                if (cur_row > ROWS - 1) cur_row = ROWS - 1;
                cur_col = (p1 - 1 > w - 1) ? w - 1 : p1 - 1;
            end
            "A": cur_row = (cur_row > cnt) ? cur_row - cnt : 0;
            "B": begin
                cur_row += cnt;
                if (cur_row > ROWS - 1) cur_row = ROWS - 1;
            end
            "C": begin
                cur_col += cnt;
                if (cur_col > w - 1) cur_col = w - 1;
            end
            "D": cur_col = (cur_col > cnt) ? cur_col - cnt : 0;
            default: ;
        endcase
    endtask

    task automatic take_byte(logic [7:0] b);
        int unsigned w, stop;
        w = cols_active();
        case (pstate)
            PS_TEXT: begin
                if (b == CH_ESC) pstate = PS_ESC;
                else if (b == CH_LF) line_feed();
                else if (b == CH_CR) cur_col = 0;
                else if (b == CH_BS) begin
                    if (cur_col > 0) begin
                        cur_col--;
                        screen[cell_addr(cur_row, cur_col)] = '0;
                    end
                end else if (b == CH_TAB) begin
                    stop = (cur_col / 8 + 1) * 8;
                    while (cur_col < stop && cur_col < w) begin
                        screen[cell_addr(cur_row, cur_col)] = CH_SP[6:0];
                        cur_col++;
                    end
                    if (cur_col >= w) line_feed();
                end else if (b >= 32 && b < 127) begin
                    screen[cell_addr(cur_row, cur_col)] = b[6:0];
                    cur_col++;
                    if (cur_col >= w) line_feed();
                end
            end
            PS_ESC: begin
                if (b == CH_LBR) begin
                    pstate = PS_CSI;
                    pidx = 0;
                    arg0 = 0;
                    arg1 = 0;
                end else if (b == CH_RBR) pstate = PS_OSC;
                else pstate = PS_TEXT;
            end
            PS_CSI: begin
                if (b >= "0" && b <= "9") begin
                    if (pidx == 0) arg0 = push_digit(arg0, b - "0");
                    else if (pidx == 1) arg1 = push_digit(arg1, b - "0");
                end else if (b == CH_SEMI) begin
                    if (pidx + 1 < MAX_PARAMS) begin
                        pidx++;
                        if (pidx == 1) arg1 = 0;
                    end
                end else if (b >= "@" && b <= "~") begin
                    run_sequence(b);
                    pstate = PS_TEXT;
                end else pstate = PS_TEXT;
            end
            default: if (b == CH_BEL || b == CH_ESC) pstate = PS_TEXT;
        endcase
    endtask

    always @(posedge i_clk) begin
        term_view_t v, got;
        if (!i_rst_n) begin
            for (int i = 0; i < ROWS*COLS; i++) screen[i] = '0;
            top_row = 0;
            cur_row = 0;
            cur_col = 0;
            pstate = PS_TEXT;
            pidx = 0;
            arg0 = 0;
            arg1 = 0;
            width_reg = WIDTH_RESET;
            expected_views.delete();
            o_fail_count = 0;
        end else begin
            if (psel && penable && pwrite && paddr[2] == ADDR_COLUMNS)
                width_reg = pwdata[7:0];
            if (i_valid && o_ready) begin
                v.ch = '0;
                if (!i_mode) take_byte(i_stream_byte);
                else if (i_read_row < ROWS && i_read_col < COLS)
                    v.ch = screen[cell_addr(i_read_row, i_read_col)];
                v.row = cur_row[7:0];
                v.col = cur_col[6:0];
                expected_views.push_back(v);
            end
            if (o_valid && i_ready) begin
                got = '{o_cell_char, o_cursor_row_out, o_cursor_col_out};
                if (expected_views.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) $display("unexpected result word %h", got);
                end else begin
                    v = expected_views.pop_front();
                    if (got !== v) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: exp cell %0d row %0d col %0d, got %0d %0d %0d",
                                     v.ch, v.row, v.col, got.ch, got.row, got.col);
                    end
                end
            end
        end
    end
endmodule

// ===== verif/ansi_text_terminal_engine_tb.sv =====
// Testbench top for the ANSI text terminal engine: stimulus and verdict.
// Depends on atte_pkg, the engine RTL and ansi_text_terminal_engine_checker.
module ansi_text_terminal_engine_tb
    import atte_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_mode = 1'b0;
    logic [7:0]  i_stream_byte = '0;
    logic [7:0]  i_read_row = '0;
    logic [6:0]  i_read_col = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [6:0]  o_cell_char;
    logic [7:0]  o_cursor_row_out;
    logic [6:0]  o_cursor_col_out;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    ansi_text_terminal_engine DUT (.*);
    ansi_text_terminal_engine_checker u_checker (.*, .o_fail_count(fail_count),
                                                 .o_pending(pending));

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver stalls
    initial begin
        int unsigned g;
        forever begin
            @(posedge i_clk);
            g = gap_len();
            if (g == 0) i_ready <= 1'b1;
            else begin
                i_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("FAIL ansi_text_terminal_engine");
            $finish;
        end
    end

    task automatic send_word(logic m, logic [7:0] b, logic [7:0] rr, logic [6:0] rc);
        int unsigned g;
        g = gap_len();
        @(posedge i_clk);
        repeat (g) @(posedge i_clk);
        i_valid <= 1'b1;
        i_mode <= m;
        i_stream_byte <= b;
        i_read_row <= rr;
        i_read_col <= rc;
        do @(posedge i_clk); while (!o_ready);
        i_valid <= 1'b0;
    endtask

    task automatic feed(logic [7:0] b);
        send_word(1'b0, b, 8'($urandom), 7'($urandom));
    endtask

    task automatic feed_str(string s);
        for (int i = 0; i < s.len(); i++) feed(s[i]);
    endtask

    task automatic read_cell(logic [7:0] rr, logic [6:0] rc);
        send_word(1'b1, 8'($urandom), rr, rc);
    endtask

    task automatic set_width(logic [31:0] w);
        while (pending != 0) @(posedge i_clk);
        repeat (ROWS*COLS + 200) @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {ADDR_COLUMNS, 2'b00};
        pwdata <= w;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic random_csi();
        int unsigned n;
        string fins;
        fins = "JKHABCDm@~";
        feed(CH_ESC);
        feed(CH_LBR);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0: feed_str($sformatf("%0d", $urandom_range(0, 300)));
                1: feed_str($sformatf("%0d", $urandom_range(0, 99999)));
                default: feed_str($sformatf("%0d", $urandom_range(0, 9)));
            endcase
            if (i + 1 < n) feed(CH_SEMI);
        end
        if ($urandom_range(0, 9) == 0) feed(8'($urandom));
        // erase display and erase line sweep many cells; keep them rare so runs stay short
        if ($urandom_range(0, 9) != 0) feed(fins[$urandom_range(2, 9)]);
        else feed(fins[$urandom_range(0, 1)]);
    endtask

    task automatic random_item();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 40) feed(8'($urandom_range(32, 126)));
        else if (k < 62)
            read_cell(8'($urandom_range(0, 20) == 0 ? $urandom : $urandom_range(0, 40)),
                      7'($urandom));
        else if (k < 68) feed(CH_LF);
        else if (k < 71) feed(CH_CR);
        else if (k < 74) feed(CH_BS);
        else if (k < 77) feed(CH_TAB);
        else if (k < 90) random_csi();
        else if (k < 93) begin
            feed(CH_ESC);
            feed(CH_RBR);
            feed_str("0;t");
            feed($urandom_range(0, 1) ? CH_BEL : CH_ESC);
        end else feed(8'($urandom));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed
        feed_str("Hi");
        feed(CH_TAB);
        feed(8'hFF);
        feed(8'd127);
        feed(CH_BS);
        feed(CH_CR);
        feed(CH_LF);
        feed_str("\033[99999;200H");
        feed_str("\033[1;2;3;4;5;6;7;8;9;1H");
        feed_str("\033[2A\033B\033[5C\033[D\033[1K\033[2K\033[K\033[1J\033[z");
        feed_str("\033]x\007\033[3J");
        read_cell(8'd0, 7'd0);
        read_cell(8'd255, 7'd127);
        // random phases across widths
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_width(32'd0);
                1: set_width(32'd255);
                2: set_width(32'd8);
                3: set_width(32'd128);
                4: set_width($urandom_range(9, 127));
                default: set_width(32'hFFFF_FF50);
            endcase
            if (ph == 2) repeat (260) feed(CH_LF);
            for (int i = 0; i < 130; i++) random_item();
        end
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) $display("PASS ansi_text_terminal_engine");
        else $display("FAIL ansi_text_terminal_engine");
        $finish;
    end
endmodule
